/* rtl/assert_macros.svh */
// Assertion macros for the checker file lpcc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked outside reset.
`define LPCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lpcc assertion failed");
// Checked at every edge, reset included.
`define LPCC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lpcc reset assertion failed");
`endif

/* rtl/lpcc_pkg.sv */
package lpcc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  // Commands.
  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_POINT = 2'd2;

  // Register indexes on the configuration port.
  localparam int APB_AW = 5;
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MINROW = 3'd2;
  localparam logic [2:0] REG_NEAR   = 3'd3;
  localparam logic [2:0] REG_FAR    = 3'd4;

  localparam logic [10:0] RST_WIDTH  = 11'd1024;
  localparam logic [10:0] RST_HEIGHT = 11'd1024;
  localparam logic [9:0]  RST_MINROW = 10'd400;
  localparam logic [30:0] RST_NEAR   = 31'd13107;
  localparam logic [30:0] RST_FAR    = 31'd655360;

  // Coefficient slots that the datapath reads.
  localparam int NUM_COEF_USED = 33;
  localparam int C_R   = 0;
  localparam int C_T   = 9;
  localparam int C_K1  = 12;
  localparam int C_K2  = 13;
  localparam int C_P1  = 14;
  localparam int C_P2  = 15;
  localparam int C_K3  = 16;
  localparam int C_FX  = 17;
  localparam int C_CX  = 18;
  localparam int C_FY  = 19;
  localparam int C_CY  = 20;
  localparam int C_P   = 21;
  localparam int C_PT  = 30;

  localparam int DIV_STEPS = 32;
  // Side data travels alongside the divider and the eleven stages after it.
  localparam int SIDE_DEPTH = DIV_STEPS + 1 + 11;

  typedef logic signed [31:0] q32_t;
  typedef logic signed [39:0] prod_t;
  typedef logic signed [41:0] cam_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [9:0]  min_row;
    logic [30:0] depth_near;
    logic [30:0] depth_far;
  } cfg_t;

  typedef struct packed {
    logic             v;
    logic             pt;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [23:0]      rgb;
    q32_t             gx;
    q32_t             gy;
    q32_t             gz;
  } side_t;

  // Product shifted right by 24 with floor rounding.
  function automatic prod_t mul24(input q32_t a, input q32_t b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:24];
  endfunction

  function automatic q32_t sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

/* rtl/lpcc_ifs.sv */
interface lpcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  coef_index;
  logic [31:0] coef_value;
  logic [9:0]  pixel_row;
  logic [9:0]  pixel_col;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;

  modport source (output valid, command, coef_index, coef_value, pixel_row, pixel_col,
                  pixel_red, pixel_green, pixel_blue, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, command, coef_index, coef_value, pixel_row, pixel_col,
                pixel_red, pixel_green, pixel_blue, point_x, point_y, point_z,
                output ready);
  modport monitor (input valid, ready, command, coef_index, coef_value, pixel_row,
                   pixel_col, pixel_red, pixel_green, pixel_blue, point_x, point_y,
                   point_z);
endinterface

interface lpcc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  color_red;
  logic [7:0]  color_green;
  logic [7:0]  color_blue;
  logic [31:0] global_x;
  logic [31:0] global_y;
  logic [31:0] global_z;

  modport source (output valid, color_red, color_green, color_blue, global_x, global_y,
                  global_z, input ready);
  modport sink (input valid, color_red, color_green, color_blue, global_x, global_y,
                global_z, output ready);
  modport monitor (input valid, ready, color_red, color_green, color_blue, global_x,
                   global_y, global_z);
endinterface

/* rtl/lpcc_ram.sv */
module lpcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/lpcc_cfg.sv */
module lpcc_cfg import lpcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] idx;

  assign idx    = paddr[APB_AW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_WIDTH;
      cfg.image_height <= RST_HEIGHT;
      cfg.min_row      <= RST_MINROW;
      cfg.depth_near   <= RST_NEAR;
      cfg.depth_far    <= RST_FAR;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_WIDTH:  cfg.image_width  <= pwdata[10:0];
        REG_HEIGHT: cfg.image_height <= pwdata[10:0];
        REG_MINROW: cfg.min_row      <= pwdata[9:0];
        REG_NEAR:   cfg.depth_near   <= pwdata[30:0];
        REG_FAR:    cfg.depth_far    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = {21'b0, cfg.image_width};
      REG_HEIGHT: prdata = {21'b0, cfg.image_height};
      REG_MINROW: prdata = {22'b0, cfg.min_row};
      REG_NEAR:   prdata = {1'b0, cfg.depth_near};
      REG_FAR:    prdata = {1'b0, cfg.depth_far};
      default:    prdata = '0;
    endcase
  end

endmodule

/* rtl/lpcc_div.sv */
module lpcc_div import lpcc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [39:0] mag,
  input  logic [30:0] den,
  input  logic        neg,
  output q32_t        quot
);

  logic [63:0]          rem_s [DIV_STEPS+1];
  logic [30:0]          den_s [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_s [DIV_STEPS+1];
  logic                 neg_s [DIV_STEPS+1];
  logic                 ovf_s [DIV_STEPS+1];
  logic [DIV_STEPS:0]   qmag;

  // A quotient of 2^32 or more is flagged up front and saturates at the end.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= {mag, 24'b0};
      den_s[0] <= den;
      quo_s[0] <= '0;
      neg_s[0] <= neg;
      ovf_s[0] <= {mag, 24'b0} >= {1'b0, den, 32'b0};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [63:0] dsh;
    logic        fits;

    assign dsh  = {33'b0, den_s[k]} << (DIV_STEPS - 1 - k);
    assign fits = rem_s[k] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= fits ? rem_s[k] - dsh : rem_s[k];
        quo_s[k+1] <= {quo_s[k][DIV_STEPS-2:0], fits};
        den_s[k+1] <= den_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  always_comb begin
    if (ovf_s[DIV_STEPS] || quo_s[DIV_STEPS] > 32'h80000000) begin
      qmag = 33'h080000000;
    end else begin
      qmag = {1'b0, quo_s[DIV_STEPS]};
    end
    if (neg_s[DIV_STEPS]) begin
      quot = 32'(-qmag);
    end else if (qmag[31]) begin
      quot = 32'sh7fffffff;
    end else begin
      quot = qmag[31:0];
    end
  end

endmodule

/* rtl/lidar_point_camera_colorizer.sv */
// Lidar point colouriser.
// Requests arrive on the items channel (valid/ready); each carries a command.
// A coefficient write loads one slot of the calibration table, a pixel write
// stores one RGB pixel in the frame store, and a point request projects one
// lidar point onto the image. A point that passes the depth window, lands
// inside the image and at or below min_row yields one request on the results
// channel with the pixel colour and the pose-transformed point; any other
// point yields nothing. Image size, minimum row and depth window sit on the
// APB port; the user must change them only while the block is idle, as the
// block itself does not enforce this. From acceptance to the result a request
// passes the input register, two stages for the camera transform, 33 for the
// pipelined divider that normalises x and y, eleven for distortion and
// projection, and one for the frame store read.
// One request is taken per cycle while the receiver does not stall; a
// coefficient write waits until the pipeline and the output register are
// empty. Reset empties the pipeline and restores the registers; the tables
// hold whatever was written. When the receiver stalls, the whole pipeline
// holds and the pending result stays on the outputs.
module lidar_point_camera_colorizer import lpcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  lpcc_in_if.sink           items,
  lpcc_out_if.source        results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t  cfg;
  q32_t  coef_r [NUM_COEF_USED];
  logic  en;
  logic  busy;
  logic  in_acc;

  side_t a_s, b_s, c_s;
  side_t side_line [SIDE_DEPTH];
  q32_t  a_lx, a_ly, a_lz;
  prod_t b_cp [9];
  prod_t b_pp [9];
  cam_t  c_cam [3];
  logic  c_pass;
  side_t c_gated;
  q32_t  div_tx, div_ty;

  q32_t  n_tx, n_ty;
  prod_t m1_xx, m1_yy, m1_xy;
  q32_t  m1_tx, m1_ty;
  q32_t  m2_r2, m2_txy, m2_sxx, m2_syy, m2_tx, m2_ty;
  prod_t m3_r4p, m3_k1r2, m3_p1txy, m3_p2txy;
  q32_t  m3_a2x, m3_a2y, m3_r2, m3_tx, m3_ty;
  q32_t  r4;
  prod_t m4_r6p, m4_k2r4, m4_p2a2x, m4_p1a2y, m4_k1r2, m4_p1txy, m4_p2txy;
  q32_t  m4_tx, m4_ty;
  prod_t m5_k3r6, m5_k1r2, m5_k2r4, m5_p1txy, m5_p2txy, m5_p2a2x, m5_p1a2y;
  q32_t  m5_tx, m5_ty;
  q32_t  m6_d, m6_tx, m6_ty;
  prod_t m6_p1txy, m6_p2txy, m6_p2a2x, m6_p1a2y;
  prod_t m7_txd, m7_tyd, m7_p1txy, m7_p2txy, m7_p2a2x, m7_p1a2y;
  q32_t  m8_ux, m8_uy;
  prod_t m9_fxu, m9_fyv;
  logic signed [25:0] m10_px, m10_py;

  side_t last_s;
  logic  hit;
  logic  q_v;
  q32_t  q_gx, q_gy, q_gz;
  logic [23:0] pix_rd;

  // Pixel rounding: (u + 0.5) truncated toward zero, Q23.16 product plus Q15.16 centre in, integer out.
  function automatic logic signed [25:0] round_pix(input prod_t p, input q32_t c);
    logic signed [47:0] w;
    logic signed [47:0] wn;
    w  = 48'(p) + 48'(c) + 48'sd32768;
    wn = -w;
    if (w < 0) begin
      return 26'(-(wn >>> 16));
    end
    return 26'(w >>> 16);
  endfunction

  lpcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign en           = !q_v || results.ready;
  assign items.ready  = en && (items.command != CMD_COEF || !busy);
  assign in_acc       = items.valid && items.ready;

  always_comb begin
    busy = a_s.v || b_s.v || c_s.v || q_v;
    for (int k = 0; k < SIDE_DEPTH; k++) begin
      busy = busy || side_line[k].v;
    end
  end

  // Coefficient writes land only when no point is in flight.
  always_ff @(posedge clk) begin
    if (in_acc && items.command == CMD_COEF) begin
      for (int k = 0; k < NUM_COEF_USED; k++) begin
        if (items.coef_index == 6'(k)) begin
          coef_r[k] <= items.coef_value;
        end
      end
    end
  end

  // Input register, camera transform and pose transform.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_s.v <= 1'b0;
      b_s.v <= 1'b0;
      c_s.v <= 1'b0;
    end else if (en) begin
      a_s.v   <= in_acc && (items.command == CMD_PIXEL || items.command == CMD_POINT);
      a_s.pt  <= items.command == CMD_POINT;
      a_s.row <= items.pixel_row[ROW_W-1:0];
      a_s.col <= items.pixel_col[COL_W-1:0];
      a_s.rgb <= {items.pixel_red, items.pixel_green, items.pixel_blue};
      a_s.gx  <= '0;
      a_s.gy  <= '0;
      a_s.gz  <= '0;
      a_lx    <= items.point_x;
      a_ly    <= items.point_y;
      a_lz    <= items.point_z;

      b_s <= a_s;
      for (int i = 0; i < 3; i++) begin
        b_cp[3*i]   <= mul24(coef_r[C_R + 3*i],     a_lz);
        b_cp[3*i+1] <= mul24(coef_r[C_R + 3*i + 1], a_lx);
        b_cp[3*i+2] <= mul24(coef_r[C_R + 3*i + 2], a_ly);
        b_pp[3*i]   <= mul24(coef_r[C_P + 3*i],     a_lx);
        b_pp[3*i+1] <= mul24(coef_r[C_P + 3*i + 1], a_ly);
        b_pp[3*i+2] <= mul24(coef_r[C_P + 3*i + 2], a_lz);
      end

      c_s.v   <= b_s.v;
      c_s.pt  <= b_s.pt;
      c_s.row <= b_s.row;
      c_s.col <= b_s.col;
      c_s.rgb <= b_s.rgb;
      c_s.gx  <= sat32(48'(b_pp[0]) + 48'(b_pp[1]) + 48'(b_pp[2]) + 48'(coef_r[C_PT]));
      c_s.gy  <= sat32(48'(b_pp[3]) + 48'(b_pp[4]) + 48'(b_pp[5]) + 48'(coef_r[C_PT + 1]));
      c_s.gz  <= sat32(48'(b_pp[6]) + 48'(b_pp[7]) + 48'(b_pp[8]) + 48'(coef_r[C_PT + 2]));
      for (int i = 0; i < 3; i++) begin
        c_cam[i] <= 42'(b_cp[3*i]) + 42'(b_cp[3*i+1]) + 42'(b_cp[3*i+2]) +
                    42'(coef_r[C_T + i] >>> 8);
      end
    end
  end

  // Points outside the depth window become bubbles here.
  always_comb begin
    c_pass    = c_cam[2] > $signed(42'(cfg.depth_near)) &&
                c_cam[2] < $signed(42'(cfg.depth_far));
    c_gated   = c_s;
    c_gated.v = c_s.v && (!c_s.pt || c_pass);
  end

  lpcc_div u_div_x (
    .clk  (clk),
    .en   (en),
    .mag  (40'(c_cam[0] < 0 ? -c_cam[0] : c_cam[0])),
    .den  (c_cam[2][30:0]),
    .neg  (c_cam[0] < 0),
    .quot (div_tx)
  );

  lpcc_div u_div_y (
    .clk  (clk),
    .en   (en),
    .mag  (40'(c_cam[1] < 0 ? -c_cam[1] : c_cam[1])),
    .den  (c_cam[2][30:0]),
    .neg  (c_cam[1] < 0),
    .quot (div_ty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SIDE_DEPTH; k++) begin
        side_line[k].v <= 1'b0;
      end
    end else if (en) begin
      side_line[0] <= c_gated;
      for (int k = 1; k < SIDE_DEPTH; k++) begin
        side_line[k] <= side_line[k-1];
      end
    end
  end

  assign r4 = sat32(48'(m3_r4p));

  // Distortion and projection.
  always_ff @(posedge clk) begin
    if (en) begin
      n_tx <= div_tx;
      n_ty <= div_ty;

      m1_xx <= mul24(n_tx, n_tx);
      m1_yy <= mul24(n_ty, n_ty);
      m1_xy <= mul24(n_tx, n_ty);
      m1_tx <= n_tx;
      m1_ty <= n_ty;

      m2_r2  <= sat32(48'(m1_xx) + 48'(m1_yy));
      m2_txy <= sat32(48'(m1_xy));
      m2_sxx <= sat32(48'(m1_xx));
      m2_syy <= sat32(48'(m1_yy));
      m2_tx  <= m1_tx;
      m2_ty  <= m1_ty;

      m3_r4p   <= mul24(m2_r2, m2_r2);
      m3_k1r2  <= mul24(coef_r[C_K1], m2_r2);
      m3_p1txy <= mul24(coef_r[C_P1], m2_txy);
      m3_p2txy <= mul24(coef_r[C_P2], m2_txy);
      m3_a2x   <= sat32(48'(m2_r2) + (48'(m2_sxx) <<< 1));
      m3_a2y   <= sat32(48'(m2_r2) + (48'(m2_syy) <<< 1));
      m3_r2    <= m2_r2;
      m3_tx    <= m2_tx;
      m3_ty    <= m2_ty;

      m4_r6p   <= mul24(r4, m3_r2);
      m4_k2r4  <= mul24(coef_r[C_K2], r4);
      m4_p2a2x <= mul24(coef_r[C_P2], m3_a2x);
      m4_p1a2y <= mul24(coef_r[C_P1], m3_a2y);
      m4_k1r2  <= m3_k1r2;
      m4_p1txy <= m3_p1txy;
      m4_p2txy <= m3_p2txy;
      m4_tx    <= m3_tx;
      m4_ty    <= m3_ty;

      m5_k3r6  <= mul24(coef_r[C_K3], sat32(48'(m4_r6p)));
      m5_k1r2  <= m4_k1r2;
      m5_k2r4  <= m4_k2r4;
      m5_p1txy <= m4_p1txy;
      m5_p2txy <= m4_p2txy;
      m5_p2a2x <= m4_p2a2x;
      m5_p1a2y <= m4_p1a2y;
      m5_tx    <= m4_tx;
      m5_ty    <= m4_ty;

      m6_d     <= sat32(48'sd16777216 + 48'(m5_k1r2) + 48'(m5_k2r4) + 48'(m5_k3r6));
      m6_p1txy <= m5_p1txy;
      m6_p2txy <= m5_p2txy;
      m6_p2a2x <= m5_p2a2x;
      m6_p1a2y <= m5_p1a2y;
      m6_tx    <= m5_tx;
      m6_ty    <= m5_ty;

      m7_txd   <= mul24(m6_tx, m6_d);
      m7_tyd   <= mul24(m6_ty, m6_d);
      m7_p1txy <= m6_p1txy;
      m7_p2txy <= m6_p2txy;
      m7_p2a2x <= m6_p2a2x;
      m7_p1a2y <= m6_p1a2y;

      m8_ux <= sat32(48'(m7_txd) + (48'(m7_p1txy) <<< 1) + 48'(m7_p2a2x));
      m8_uy <= sat32(48'(m7_tyd) + 48'(m7_p1a2y) + (48'(m7_p2txy) <<< 1));

      m9_fxu <= mul24(coef_r[C_FX], m8_ux);
      m9_fyv <= mul24(coef_r[C_FY], m8_uy);

      m10_px <= round_pix(m9_fxu, coef_r[C_CX]);
      m10_py <= round_pix(m9_fyv, coef_r[C_CY]);
    end
  end

  assign last_s = side_line[SIDE_DEPTH-1];
  assign hit    = m10_px >= 0 && m10_px < $signed(26'(cfg.image_width)) &&
                  m10_px < 26'(MAX_WIDTH) &&
                  m10_py >= $signed(26'(cfg.min_row)) &&
                  m10_py < $signed(26'(cfg.image_height)) &&
                  m10_py < 26'(MAX_HEIGHT);

  // Pixel writes and point reads meet the frame store at the same stage, so
  // they keep the order in which they were accepted.
  lpcc_ram #(
    .WIDTH (24),
    .DEPTH (PIX_DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (en && last_s.v && !last_s.pt),
    .waddr ({last_s.row, last_s.col}),
    .wdata (last_s.rgb),
    .re    (en),
    .raddr ({m10_py[ROW_W-1:0], m10_px[COL_W-1:0]}),
    .rdata (pix_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else if (en) begin
      q_v <= last_s.v && last_s.pt && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_gx <= last_s.gx;
      q_gy <= last_s.gy;
      q_gz <= last_s.gz;
    end
  end

  assign results.valid       = q_v;
  assign results.color_red   = pix_rd[23:16];
  assign results.color_green = pix_rd[15:8];
  assign results.color_blue  = pix_rd[7:0];
  assign results.global_x    = q_gx;
  assign results.global_y    = q_gy;
  assign results.global_z    = q_gz;

endmodule

/* rtl/lpcc_checker.sv */
`include "assert_macros.svh"

module lpcc_props import lpcc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_gx,
  input logic [7:0]  out_red
);

  // A coefficient write is taken only while the output holds no result.
  `LPCC_ASSERT(a_coef_drained, in_valid && in_ready && in_command == CMD_COEF |-> !out_valid)
  // Other requests are refused only under back-pressure from the receiver.
  `LPCC_ASSERT(a_stall_source, in_valid && !in_ready && in_command != CMD_COEF |-> out_valid && !out_ready)
  `LPCC_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(out_gx) && $stable(out_red))
  `LPCC_ASSERT_RST(a_reset_clears, rst |=> !out_valid)

endmodule

bind lidar_point_camera_colorizer lpcc_props u_lpcc_props (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (items.valid),
  .in_ready   (items.ready),
  .in_command (items.command),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_gx     (results.global_x),
  .out_red    (results.color_red)
);
